// ----- src/stq_pkg.sv -----
// Shared types and constants of the sorted timeout queue.
package stq_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned BURST_W     = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_CANCEL  = 2'd2,
        CMD_SERVICE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_REMOVED   = 3'd3,
        STATUS_EXPIRED   = 3'd4,
        STATUS_NONE_DUE  = 3'd5
    } status_t;

    typedef enum logic {
        FSM_IDLE    = 1'b0,
        FSM_SERVICE = 1'b1
    } fsm_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] deadline;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] arg;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] deadline;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] arg;
    } cell_ctl_t;

endpackage

// ----- src/stq_cell.sv -----
// One queue cell: holds an entry and shifts it toward or away from the head.
module stq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  stq_pkg::cell_ctl_t ctl,
    input  stq_pkg::entry_t    prev_entry,
    input  stq_pkg::entry_t    next_entry,
    input  logic               prev_le,
    input  logic               found_in,
    output stq_pkg::entry_t    entry,
    output logic               le_out,
    output logic               found_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [stq_pkg::WORD_W-1:0]    deadline_reg;
    logic [stq_pkg::WORD_W-1:0]    deadline_next;
    logic [stq_pkg::WORD_W-1:0]    tag_reg;
    logic [stq_pkg::WORD_W-1:0]    tag_next;
    logic [stq_pkg::WORD_W-1:0]    arg_reg;
    logic [stq_pkg::WORD_W-1:0]    arg_next;
    logic                          match;

    assign entry.valid    = valid_reg;
    assign entry.deadline = deadline_reg;
    assign entry.tag      = tag_reg;
    assign entry.arg      = arg_reg;

    assign le_out    = valid_reg && (deadline_reg <= ctl.deadline);
    assign match     = valid_reg && (tag_reg == ctl.tag) && (arg_reg == ctl.arg);
    assign found_out = found_in || match;

    always_comb begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        arg_next      = arg_reg;
        case (ctl.op)
            stq_pkg::OP_INSERT: begin
                if (!le_out) begin
                    if (prev_le) begin
                        valid_next    = 1'b1;
                        deadline_next = ctl.deadline;
                        tag_next      = ctl.tag;
                        arg_next      = ctl.arg;
                    end else begin
                        valid_next    = prev_entry.valid;
                        deadline_next = prev_entry.deadline;
                        tag_next      = prev_entry.tag;
                        arg_next      = prev_entry.arg;
                    end
                end
            end
            stq_pkg::OP_REMOVE: begin
                if (found_out) begin
                    valid_next    = next_entry.valid;
                    deadline_next = next_entry.deadline;
                    tag_next      = next_entry.tag;
                    arg_next      = next_entry.arg;
                end
            end
            stq_pkg::OP_POP: begin
                valid_next    = next_entry.valid;
                deadline_next = next_entry.deadline;
                tag_next      = next_entry.tag;
                arg_next      = next_entry.arg;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
        arg_reg      <= arg_next;
    end

endmodule

// ----- src/sorted_timeout_queue_top.sv -----
// Top level of the sorted timeout queue: command decode, tick counter and cell row.
//
// Commands arrive on the s_ stream: s_tuser carries the command code and s_tdata
// the callback tag, callback argument and interval. Results leave on the m_ stream:
// m_tuser carries the status, m_tdata the wakeup flag, tag, argument and deadline,
// and m_tlast marks the final result of a command.
// Tick, set and cancel: the command is accepted, every cell compares its entry
// against the command and shifts in the same cycle, and the single result sits
// in the output register on the next cycle.
// Service first enters the service state, and its first result is loaded into
// the output register from that state. It then delivers one due entry per cycle
// from the head of the row while the output is free, up to 16 per command, or one
// nothing-due result; a new command is taken after the last one.
// The row of SLOTS cells keeps entries sorted by deadline, older first on ties.
// Reset clears the tick counter and empties the row; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the block
// stops accepting commands and popping entries until the result is taken.
module sorted_timeout_queue_top #(
    parameter int SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [95:0]  s_tdata,   // callback_tag, callback_arg, interval
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [103:0] m_tdata,   // wakeup, out_tag, out_arg, out_deadline, zero pad
    output logic         m_tlast
);

    localparam int unsigned W = stq_pkg::WORD_W;

    stq_pkg::entry_t    entries [SLOTS];
    logic               le      [SLOTS];
    logic               found   [SLOTS];
    stq_pkg::cell_ctl_t ctl;
    stq_pkg::cell_op_t  cell_op;
    stq_pkg::entry_t    second_entry;

    stq_pkg::fsm_t                 state_reg;
    stq_pkg::fsm_t                 state_next;
    logic [W-1:0]                  count_reg;
    logic [W-1:0]                  count_next;
    logic [stq_pkg::BURST_W-1:0]   burst_reg;
    logic [stq_pkg::BURST_W-1:0]   burst_next;

    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [2:0]                    m_tuser_reg;
    logic [2:0]                    m_tuser_next;
    logic [103:0]                  m_tdata_reg;
    logic [103:0]                  m_tdata_next;
    logic                          m_tlast_reg;
    logic                          m_tlast_next;

    logic                          out_free;
    logic                          accept;
    stq_pkg::cmd_t                 cmd;
    logic [W-1:0]                  in_tag;
    logic [W-1:0]                  in_arg;
    logic [W-1:0]                  in_interval;
    logic [W-1:0]                  count_inc;
    logic [W-1:0]                  set_deadline;
    logic                          head_due;
    logic                          second_due;
    logic                          burst_end;

    assign cmd          = stq_pkg::cmd_t'(s_tuser);
    assign in_tag       = s_tdata[31:0];
    assign in_arg       = s_tdata[63:32];
    assign in_interval  = s_tdata[95:64];
    assign count_inc    = count_reg + 32'd1;
    assign set_deadline = count_reg + in_interval;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == stq_pkg::FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign ctl = '{op: cell_op, deadline: set_deadline, tag: in_tag, arg: in_arg};

    generate
        if (SLOTS > 1) begin : g_second
            assign second_entry = entries[1];
        end else begin : g_no_second
            assign second_entry = '0;
        end
    endgenerate

    assign head_due   = entries[0].valid && (entries[0].deadline <= count_reg);
    assign second_due = second_entry.valid && (second_entry.deadline <= count_reg);
    assign burst_end  = !second_due ||
                        (burst_reg == stq_pkg::BURST_W'(stq_pkg::MAX_RESULTS - 1));

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            stq_pkg::entry_t prev_e;
            stq_pkg::entry_t next_e;
            logic            prev_le_w;
            logic            found_in_w;
            if (gi == 0) begin : g_head
                assign prev_e     = '0;
                assign prev_le_w  = 1'b1;
                assign found_in_w = 1'b0;
            end else begin : g_body
                assign prev_e     = entries[gi-1];
                assign prev_le_w  = le[gi-1];
                assign found_in_w = found[gi-1];
            end
            if (gi == SLOTS - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = entries[gi+1];
            end
            stq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .prev_le    (prev_le_w),
                .found_in   (found_in_w),
                .entry      (entries[gi]),
                .le_out     (le[gi]),
                .found_out  (found[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::FSM_IDLE: begin
                if (accept && (cmd == stq_pkg::CMD_SERVICE)) begin
                    state_next = stq_pkg::FSM_SERVICE;
                end
            end
            stq_pkg::FSM_SERVICE: begin
                if (out_free && (!head_due || burst_end)) begin
                    state_next = stq_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_op       = stq_pkg::OP_HOLD;
        count_next    = count_reg;
        burst_next    = burst_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            stq_pkg::FSM_IDLE: begin
                if (accept) begin
                    m_tdata_next = '0;
                    m_tlast_next = 1'b1;
                    case (cmd)
                        stq_pkg::CMD_TICK: begin
                            count_next      = count_inc;
                            m_tvalid_next   = 1'b1;
                            m_tuser_next    = stq_pkg::STATUS_OK;
                            m_tdata_next[0] = entries[0].valid &&
                                              (entries[0].deadline <= count_inc);
                        end
                        stq_pkg::CMD_SET: begin
                            m_tvalid_next = 1'b1;
                            if (entries[SLOTS-1].valid) begin
                                m_tuser_next = stq_pkg::STATUS_FULL;
                            end else begin
                                cell_op              = stq_pkg::OP_INSERT;
                                m_tuser_next         = stq_pkg::STATUS_OK;
                                m_tdata_next[96:65]  = set_deadline;
                            end
                        end
                        stq_pkg::CMD_CANCEL: begin
                            cell_op       = stq_pkg::OP_REMOVE;
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = found[SLOTS-1] ? stq_pkg::STATUS_REMOVED
                                                           : stq_pkg::STATUS_NOT_FOUND;
                        end
                        default: begin
                            burst_next = '0;
                        end
                    endcase
                end
            end
            stq_pkg::FSM_SERVICE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (head_due) begin
                        cell_op             = stq_pkg::OP_POP;
                        burst_next          = burst_reg + stq_pkg::BURST_W'(1);
                        m_tuser_next        = stq_pkg::STATUS_EXPIRED;
                        m_tdata_next[32:1]  = entries[0].tag;
                        m_tdata_next[64:33] = entries[0].arg;
                        m_tdata_next[96:65] = entries[0].deadline;
                        m_tlast_next        = burst_end;
                    end else begin
                        m_tuser_next = stq_pkg::STATUS_NONE_DUE;
                        m_tlast_next = 1'b1;
                    end
                end
            end
            default: begin
                cell_op = stq_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stq_pkg::FSM_IDLE;
            count_reg    <= '0;
            burst_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            burst_reg    <= burst_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
